[hw/rtl/bded_pkg.sv]
// bded_pkg: shared types and constants of the button debounce event detector
// holds register indexes, reset values, stream widths and the item and flag structs
// no dependencies
package bded_pkg;

    // configuration register indexes (byte address bits [4:2])
    localparam int unsigned       CFG_ADDR_W         = 5;
    localparam logic [2:0]        REG_ENABLE         = 3'd0;
    localparam logic [2:0]        REG_PRESSED_LEVEL  = 3'd1;
    localparam logic [2:0]        REG_DEBOUNCE_MS    = 3'd2;
    localparam logic [2:0]        REG_DOUBLE_CLICK   = 3'd3;
    localparam logic [2:0]        REG_HOLD_MS        = 3'd4;
    localparam logic [2:0]        REG_COUNT_WINDOW   = 3'd5;

    // register reset values
    localparam logic              RST_ENABLE         = 1'b1;
    localparam logic              RST_PRESSED_LEVEL  = 1'b1;
    localparam logic [15:0]       RST_DEBOUNCE_MS    = 16'd30;
    localparam logic [15:0]       RST_DOUBLE_CLICK   = 16'd400;
    localparam logic [15:0]       RST_HOLD_MS        = 16'd1200;
    localparam logic [31:0]       RST_COUNT_WINDOW   = 32'd0;

    // stream widths
    localparam int unsigned       IN_TDATA_W         = 40;
    localparam int unsigned       OUT_TDATA_W        = 16;

    typedef struct packed {
        logic        enable;
        logic        pressed_level;
        logic [15:0] debounce_ms;
        logic [15:0] double_click_ms;
        logic [15:0] hold_ms;
        logic [31:0] count_window_ms;
    } cfg_t;

    typedef struct packed {
        logic        level;
        logic [31:0] now;
        logic        ack_press;
        logic        ack_release;
        logic        ack_change;
        logic        ack_hold;
        logic        clear_count;
    } in_item_t;

    typedef struct packed {
        logic       is_pressed;
        logic       just_pressed;
        logic       just_released;
        logic       changed;
        logic       hold_ready;
        logic       double_click;
        logic [7:0] press_count;
    } out_item_t;

    // single-bit state of the detector plus the press counter
    typedef struct packed {
        logic       prev_sample;
        logic       debounce_armed;
        logic       prev_stable;
        logic       stable_level;
        logic       pressed_flag;
        logic       released_flag;
        logic       hold_pending;
        logic       hold_seen;
        logic       change_flag;
        logic       press_event;
        logic       release_event;
        logic       press_valid_latest;
        logic       press_valid_earlier;
        logic [7:0] count_value;
    } flags_t;

    localparam flags_t FLAGS_RST = '{
        prev_sample:         1'b0,
        debounce_armed:      1'b0,
        prev_stable:         1'b0,
        stable_level:        1'b0,
        pressed_flag:        1'b0,
        released_flag:       1'b1,
        hold_pending:        1'b0,
        hold_seen:           1'b0,
        change_flag:         1'b0,
        press_event:         1'b0,
        release_event:       1'b0,
        press_valid_latest:  1'b0,
        press_valid_earlier: 1'b0,
        count_value:         8'd0
    };

endpackage

[hw/rtl/bded_step.sv]
// bded_step: next-state and result logic for one pin sample
// purely combinational; uses bded_pkg types
// times are kept modulo 2**TIME_BITS
module bded_step #(
    parameter int unsigned TIME_BITS = 32
) (
    input  bded_pkg::cfg_t      cfg,
    input  bded_pkg::in_item_t  item,
    input  bded_pkg::flags_t    flags_cur,
    input  logic [TIME_BITS-1:0] deb_start_cur,
    input  logic [TIME_BITS-1:0] early_press_cur,
    input  logic [TIME_BITS-1:0] late_press_cur,
    input  logic [TIME_BITS-1:0] early_rel_cur,
    input  logic [TIME_BITS-1:0] late_rel_cur,
    output bded_pkg::flags_t    flags_next,
    output logic [TIME_BITS-1:0] deb_start_next,
    output logic [TIME_BITS-1:0] early_press_next,
    output logic [TIME_BITS-1:0] late_press_next,
    output logic [TIME_BITS-1:0] early_rel_next,
    output logic [TIME_BITS-1:0] late_rel_next,
    output bded_pkg::out_item_t result
);

    logic [63:0]          now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic                 hold_ack;
    logic [TIME_BITS-1:0] late_press_ack;
    logic [TIME_BITS-1:0] deb_diff;
    logic [TIME_BITS-1:0] cnt_diff;
    logic [TIME_BITS-1:0] hold_diff;
    logic [TIME_BITS-1:0] rel_gap;
    logic                 deb_expired;
    logic                 cnt_in_window;
    logic                 hold_expired;

    // timestamp folded to the time width
    assign now_ext = 64'(item.now);
    assign now_t   = now_ext[TIME_BITS-1:0];

    // hold acknowledge restarts the press time before the sample step
    assign hold_ack       = item.ack_hold & flags_cur.hold_pending;
    assign late_press_ack = hold_ack ? now_t : late_press_cur;

    // elapsed times and their compares
    assign deb_diff      = now_t - deb_start_cur;
    assign cnt_diff      = now_t - early_press_cur;
    assign hold_diff     = now_t - late_press_ack;
    assign deb_expired   = 64'(deb_diff) > 64'(cfg.debounce_ms);
    assign cnt_in_window = 64'(cnt_diff) < 64'(cfg.count_window_ms);
    assign hold_expired  = 64'(hold_diff) > 64'(cfg.hold_ms);

    // acknowledges, then the sample step
    always_comb begin
        flags_next       = flags_cur;
        deb_start_next   = deb_start_cur;
        early_press_next = early_press_cur;
        late_press_next  = late_press_ack;
        early_rel_next   = early_rel_cur;
        late_rel_next    = late_rel_cur;

        if (item.ack_press) begin
            flags_next.press_event = 1'b0;
        end
        if (item.ack_release) begin
            flags_next.release_event = 1'b0;
        end
        if (item.ack_change) begin
            flags_next.change_flag = 1'b0;
        end
        if (hold_ack) begin
            flags_next.hold_pending       = 1'b0;
            flags_next.hold_seen          = 1'b1;
            flags_next.press_valid_latest = 1'b1;
        end
        if (item.clear_count) begin
            flags_next.count_value = 8'd0;
        end

        if (cfg.enable) begin
            if (item.level != flags_cur.prev_sample) begin
                // edge seen: restart the stability timer
                deb_start_next            = now_t;
                flags_next.debounce_armed = 1'b1;
            end else if (flags_cur.debounce_armed && deb_expired) begin
                // level has been stable long enough
                flags_next.debounce_armed = 1'b0;
                flags_next.prev_stable    = flags_cur.stable_level;
                flags_next.stable_level   = item.level;
                flags_next.hold_pending   = 1'b0;
                if (item.level == cfg.pressed_level) begin
                    flags_next.pressed_flag  = 1'b1;
                    flags_next.released_flag = 1'b0;
                    flags_next.release_event = 1'b0;
                end else begin
                    flags_next.pressed_flag  = 1'b0;
                    flags_next.released_flag = 1'b1;
                    flags_next.press_event   = 1'b0;
                end
                if (flags_cur.stable_level != item.level) begin
                    flags_next.change_flag = 1'b1;
                end else begin
                    flags_next.change_flag   = 1'b0;
                    flags_next.press_event   = 1'b0;
                    flags_next.release_event = 1'b0;
                end
                if (flags_next.hold_seen) begin
                    // first level after a hold acknowledge raises no event
                    flags_next.hold_seen = 1'b0;
                end else if (flags_next.change_flag) begin
                    if (flags_next.pressed_flag) begin
                        flags_next.press_event   = 1'b1;
                        flags_next.release_event = 1'b0;
                        if (cfg.count_window_ms != 32'd0) begin
                            if (flags_cur.press_valid_earlier && cnt_in_window) begin
                                flags_next.count_value = 8'(flags_next.count_value + 8'd1);
                            end else begin
                                flags_next.count_value = 8'd1;
                            end
                        end
                        early_press_next               = late_press_ack;
                        flags_next.press_valid_earlier = flags_next.press_valid_latest;
                        late_press_next                = now_t;
                        flags_next.press_valid_latest  = 1'b1;
                    end else if (flags_next.released_flag) begin
                        flags_next.press_event   = 1'b0;
                        flags_next.release_event = 1'b1;
                        early_rel_next           = late_rel_cur;
                        late_rel_next            = now_t;
                    end
                end
            end else if (flags_cur.pressed_flag && hold_expired) begin
                flags_next.hold_pending = 1'b1;
            end
            flags_next.prev_sample = item.level;
        end
    end

    // result fields taken after the step
    assign rel_gap = late_rel_next - early_rel_next;

    always_comb begin
        result.is_pressed    = flags_next.pressed_flag;
        result.just_pressed  = flags_next.press_event;
        result.just_released = flags_next.release_event;
        result.changed       = flags_next.change_flag;
        result.hold_ready    = flags_next.hold_pending;
        result.double_click  = flags_next.release_event &&
                               (64'(rel_gap) <= 64'(cfg.double_click_ms));
        result.press_count   = flags_next.count_value;
    end

endmodule

[hw/rtl/button_debounce_event_detector_top.sv]
// button_debounce_event_detector_top: stream wrapper, register file and state of the detector
// instantiates bded_step; uses bded_pkg
//
//  channel   dir  ports                       item
//  s_        in   s_tvalid s_tready s_tdata   one pin sample with time and acknowledges
//  m_        out  m_tvalid m_tready m_tdata   one event result per sample
//  apb       in   psel penable pwrite paddr   six configuration registers at 4*index
//
// one sample per cycle sustained while m_tready holds; a result is offered once its sample
// has passed the input register and the combinational step logic into the result register
// the input register keeps taking one more sample while a result waits on m_tready
// reset puts all detector state to reset values, loads register defaults; no clearing pass
module button_debounce_event_detector_top #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bded_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // sample stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // level[0], now[32:1], ack_press[33], ack_release[34], ack_change[35],
    // ack_hold[36], clear_count[37], zero[39:38]
    input  logic [bded_pkg::IN_TDATA_W-1:0] s_tdata,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // is_pressed[0], just_pressed[1], just_released[2], changed[3],
    // hold_ready[4], double_click[5], press_count[13:6], zero[15:14]
    output logic [bded_pkg::OUT_TDATA_W-1:0] m_tdata
);

    bded_pkg::cfg_t      cfg_reg;
    bded_pkg::in_item_t  in_item_reg;
    logic                in_vld_reg;
    bded_pkg::out_item_t res_reg;
    logic                m_vld_reg;
    bded_pkg::flags_t    flags_reg;
    bded_pkg::flags_t    flags_next;
    logic [TIME_BITS-1:0] deb_start_reg,   deb_start_next;
    logic [TIME_BITS-1:0] early_press_reg, early_press_next;
    logic [TIME_BITS-1:0] late_press_reg,  late_press_next;
    logic [TIME_BITS-1:0] early_rel_reg,   early_rel_next;
    logic [TIME_BITS-1:0] late_rel_reg,    late_rel_next;
    bded_pkg::out_item_t res_next;
    bded_pkg::in_item_t  s_item;
    logic                cfg_wr;
    logic                s_xfer;
    logic                adv;

    // configuration writes
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= bded_pkg::RST_ENABLE;
            cfg_reg.pressed_level   <= bded_pkg::RST_PRESSED_LEVEL;
            cfg_reg.debounce_ms     <= bded_pkg::RST_DEBOUNCE_MS;
            cfg_reg.double_click_ms <= bded_pkg::RST_DOUBLE_CLICK;
            cfg_reg.hold_ms         <= bded_pkg::RST_HOLD_MS;
            cfg_reg.count_window_ms <= bded_pkg::RST_COUNT_WINDOW;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                bded_pkg::REG_ENABLE:        cfg_reg.enable          <= pwdata[0];
                bded_pkg::REG_PRESSED_LEVEL: cfg_reg.pressed_level   <= pwdata[0];
                bded_pkg::REG_DEBOUNCE_MS:   cfg_reg.debounce_ms     <= pwdata[15:0];
                bded_pkg::REG_DOUBLE_CLICK:  cfg_reg.double_click_ms <= pwdata[15:0];
                bded_pkg::REG_HOLD_MS:       cfg_reg.hold_ms         <= pwdata[15:0];
                bded_pkg::REG_COUNT_WINDOW:  cfg_reg.count_window_ms <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            bded_pkg::REG_ENABLE:        prdata = 32'(cfg_reg.enable);
            bded_pkg::REG_PRESSED_LEVEL: prdata = 32'(cfg_reg.pressed_level);
            bded_pkg::REG_DEBOUNCE_MS:   prdata = 32'(cfg_reg.debounce_ms);
            bded_pkg::REG_DOUBLE_CLICK:  prdata = 32'(cfg_reg.double_click_ms);
            bded_pkg::REG_HOLD_MS:       prdata = 32'(cfg_reg.hold_ms);
            bded_pkg::REG_COUNT_WINDOW:  prdata = cfg_reg.count_window_ms;
            default:                     prdata = 32'd0;
        endcase
    end

    // unpack the sample transfer
    always_comb begin
        s_item.level       = s_tdata[0];
        s_item.now         = s_tdata[32:1];
        s_item.ack_press   = s_tdata[33];
        s_item.ack_release = s_tdata[34];
        s_item.ack_change  = s_tdata[35];
        s_item.ack_hold    = s_tdata[36];
        s_item.clear_count = s_tdata[37];
    end

    // handshakes: the step fires when the input register is full and the result slot frees
    assign adv      = in_vld_reg & (~m_vld_reg | m_tready);
    assign s_tready = ~in_vld_reg | adv;
    assign s_xfer   = s_tvalid & s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_xfer) begin
            in_vld_reg <= 1'b1;
        end else if (adv) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
    end

    // step logic
    bded_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg              (cfg_reg),
        .item             (in_item_reg),
        .flags_cur        (flags_reg),
        .deb_start_cur    (deb_start_reg),
        .early_press_cur  (early_press_reg),
        .late_press_cur   (late_press_reg),
        .early_rel_cur    (early_rel_reg),
        .late_rel_cur     (late_rel_reg),
        .flags_next       (flags_next),
        .deb_start_next   (deb_start_next),
        .early_press_next (early_press_next),
        .late_press_next  (late_press_next),
        .early_rel_next   (early_rel_next),
        .late_rel_next    (late_rel_next),
        .result           (res_next)
    );

    // detector state advances with each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg       <= bded_pkg::FLAGS_RST;
            deb_start_reg   <= '0;
            early_press_reg <= '0;
            late_press_reg  <= '0;
            early_rel_reg   <= '0;
            late_rel_reg    <= '0;
        end else if (adv) begin
            flags_reg       <= flags_next;
            deb_start_reg   <= deb_start_next;
            early_press_reg <= early_press_next;
            late_press_reg  <= late_press_next;
            early_rel_reg   <= early_rel_next;
            late_rel_reg    <= late_rel_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    // pack the result transfer
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {2'b00,
                       res_reg.press_count,
                       res_reg.double_click,
                       res_reg.hold_ready,
                       res_reg.changed,
                       res_reg.just_released,
                       res_reg.just_pressed,
                       res_reg.is_pressed};

endmodule
